### rtl/rmpss_pkg.sv
// ----------------------------------------------------------------------------
// rmpss_pkg
// Shared types and constants of the range maximum prefix/suffix sum block.
// ----------------------------------------------------------------------------
package rmpss_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned LEVELS_DEF       = 11;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned SUM_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_PREFIX = 2'd1,
    CMD_SUFFIX = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_LVL,
    S_BLD_LO,
    S_BLD_HI,
    S_BLD_WR,
    S_Q_WALK,
    S_Q_DRAIN
  } state_e;

  // One table entry: block sum, best prefix sum and best suffix sum.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] pre;
    logic signed [SUM_W-1:0] suf;
  } entry_t;

endpackage

### rtl/rmpss_ram.sv
// ----------------------------------------------------------------------------
// rmpss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rmpss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rmpss_merge.sv
// ----------------------------------------------------------------------------
// rmpss_merge
// Combines two adjacent half blocks into the entry of the doubled block.
// ----------------------------------------------------------------------------
module rmpss_merge (
  input  rmpss_pkg::entry_t lo_i,
  input  rmpss_pkg::entry_t hi_i,
  output rmpss_pkg::entry_t out_o
);

  logic signed [rmpss_pkg::SUM_W-1:0] lo_plus_pre;
  logic signed [rmpss_pkg::SUM_W-1:0] suf_plus_hi;

  assign lo_plus_pre = lo_i.sum + hi_i.pre;
  assign suf_plus_hi = lo_i.suf + hi_i.sum;

  assign out_o.sum = lo_i.sum + hi_i.sum;
  assign out_o.pre = (lo_i.pre > lo_plus_pre) ? lo_i.pre : lo_plus_pre;
  assign out_o.suf = (suf_plus_hi > hi_i.suf) ? suf_plus_hi : hi_i.suf;

endmodule

### rtl/range_max_prefix_suffix_sum.sv
// ----------------------------------------------------------------------------
// range_max_prefix_suffix_sum
// Range maximum prefix/suffix sum from power-of-two doubling tables.
// ----------------------------------------------------------------------------
// Clears and loads that are not flagged last complete in the idle state and never
// raise busy_o. The load flagged last starts the table build, which holds busy_o
// while it runs: per level a level check, then per table entry the steps (one
// table RAM with a single read port) read low half, read high half, write. A
// load into a full store answers with the full status on the next cycle, or at
// the end of the build when it is flagged last. A query walks one table level per
// cycle, then passes a drain state and a registered result; bad or early queries
// answer on the next cycle. Each result shows for one cycle with done_o and must
// be taken then: there is no back pressure.
module range_max_prefix_suffix_sum #(
  parameter int unsigned MAX_ELEMENTS = rmpss_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned LEVELS       = rmpss_pkg::LEVELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          command_i,
  input  logic signed [rmpss_pkg::ELEM_W-1:0] element_value_i,
  input  logic                                last_element_i,
  input  logic [rmpss_pkg::IDX_W-1:0]         left_index_i,
  input  logic [rmpss_pkg::IDX_W-1:0]         right_index_i,
  output logic                                done_o,
  output logic signed [rmpss_pkg::SUM_W-1:0]  best_sum_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned DEPTH = MAX_ELEMENTS * LEVELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned WW0   = (CW > LEVELS + 1) ? CW : LEVELS + 1;
  localparam int unsigned WW    = (WW0 > rmpss_pkg::IDX_W + 1) ? WW0 : rmpss_pkg::IDX_W + 1;
  localparam int unsigned LVW   = $clog2(LEVELS + 1);
  localparam int unsigned EW    = $bits(rmpss_pkg::entry_t);

  rmpss_pkg::state_e state_q, state_d;

  logic [CW-1:0]  count_q, count_d;
  logic           built_q, built_d;
  logic           full_pend_q, full_pend_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [WW-1:0]  idx_q, idx_d;
  logic [WW-1:0]  qleft_q, qleft_d;
  logic [WW-1:0]  qlen_q, qlen_d;
  logic           qsuf_q, qsuf_d;
  logic           pend_q, pend_d;
  logic           have_q, have_d;
  logic signed [rmpss_pkg::SUM_W-1:0] run_q, run_d;
  logic signed [rmpss_pkg::SUM_W-1:0] acc_q, acc_d;
  rmpss_pkg::entry_t lo_q, lo_d;

  logic           done_q, done_d;
  logic signed [rmpss_pkg::SUM_W-1:0] res_q, res_d;
  logic [1:0]     stat_q, stat_d;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  rmpss_pkg::entry_t wdata, rdata, merged;

  logic           accept;
  logic           full;
  logic [WW-1:0]  span_b, half_b, span_q, len_in, right_w, left_w;
  logic signed [rmpss_pkg::SUM_W-1:0] cand, sufc, acc_next, run_next;
  logic signed [rmpss_pkg::SUM_W-1:0] elem_ext;

  function automatic logic [AW-1:0] slot(input logic [WW-1:0] start,
                                         input logic [LVW-1:0] level);
    slot = AW'(AW'(level) * AW'(MAX_ELEMENTS) + AW'(start));
  endfunction

  rmpss_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rmpss_merge u_merge (
    .lo_i (lo_q),
    .hi_i (rdata),
    .out_o(merged)
  );

  assign accept   = start_i && (state_q == rmpss_pkg::S_IDLE);
  assign full     = (WW'(count_q) >= WW'(MAX_ELEMENTS));
  assign span_b   = WW'(1) << lvl_q;
  assign half_b   = span_b >> 1;
  assign span_q   = WW'(1) << lvl_q;
  assign left_w   = WW'(left_index_i);
  assign right_w  = WW'(right_index_i);
  assign len_in   = right_w - left_w + WW'(1);
  assign elem_ext = rmpss_pkg::SUM_W'(element_value_i);

  // Accumulation of the block read in the previous walk cycle.
  assign cand     = run_q + rdata.pre;
  assign sufc     = acc_q + rdata.sum;
  assign run_next = run_q + rdata.sum;
  always_comb begin
    if (qsuf_q) begin
      acc_next = (have_q && (sufc > rdata.suf)) ? sufc : rdata.suf;
    end else begin
      acc_next = (have_q && (acc_q > cand)) ? acc_q : cand;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    built_d     = built_q;
    full_pend_d = full_pend_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    qleft_d     = qleft_q;
    qlen_d      = qlen_q;
    qsuf_d      = qsuf_q;
    pend_d      = 1'b0;
    have_d      = have_q;
    run_d       = run_q;
    acc_d       = acc_q;
    lo_d        = lo_q;
    done_d      = 1'b0;
    res_d       = '0;
    stat_d      = rmpss_pkg::ST_OK;
    we          = 1'b0;
    waddr       = '0;
    wdata       = merged;
    raddr       = '0;

    if (pend_q) begin
      have_d = 1'b1;
      run_d  = run_next;
      acc_d  = acc_next;
    end

    case (state_q)
      rmpss_pkg::S_IDLE: begin
        if (accept) begin
          case (rmpss_pkg::cmd_e'(command_i))
            rmpss_pkg::CMD_LOAD: begin
              if (!full) begin
                we      = 1'b1;
                waddr   = slot(WW'(count_q), '0);
                wdata   = '{sum: elem_ext, pre: elem_ext, suf: elem_ext};
                count_d = count_q + CW'(1);
                built_d = 1'b0;
              end
              full_pend_d = full;
              if (last_element_i) begin
                lvl_d   = LVW'(1);
                state_d = rmpss_pkg::S_BLD_LVL;
              end else if (full) begin
                done_d = 1'b1;
                stat_d = rmpss_pkg::ST_FULL;
              end
            end
            rmpss_pkg::CMD_CLEAR: begin
              count_d = '0;
              built_d = 1'b0;
            end
            default: begin
              if (!built_q) begin
                done_d = 1'b1;
                stat_d = rmpss_pkg::ST_NOT_BUILT;
              end else if ((left_w > right_w) || (right_w >= WW'(count_q)) ||
                           (len_in >= (WW'(1) << LEVELS))) begin
                done_d = 1'b1;
                stat_d = rmpss_pkg::ST_BAD_RANGE;
              end else begin
                qleft_d = left_w;
                qlen_d  = len_in;
                qsuf_d  = (command_i == rmpss_pkg::CMD_SUFFIX);
                lvl_d   = LVW'(LEVELS - 1);
                have_d  = 1'b0;
                run_d   = '0;
                acc_d   = '0;
                state_d = rmpss_pkg::S_Q_WALK;
              end
            end
          endcase
        end
      end
      rmpss_pkg::S_BLD_LVL: begin
        if ((lvl_q == LVW'(LEVELS)) || (span_b > WW'(count_q))) begin
          built_d = 1'b1;
          state_d = rmpss_pkg::S_IDLE;
          if (full_pend_q) begin
            done_d = 1'b1;
            stat_d = rmpss_pkg::ST_FULL;
          end
        end else begin
          idx_d   = '0;
          state_d = rmpss_pkg::S_BLD_LO;
        end
      end
      rmpss_pkg::S_BLD_LO: begin
        raddr   = slot(idx_q, lvl_q - LVW'(1));
        state_d = rmpss_pkg::S_BLD_HI;
      end
      rmpss_pkg::S_BLD_HI: begin
        raddr   = slot(idx_q + half_b, lvl_q - LVW'(1));
        lo_d    = rdata;
        state_d = rmpss_pkg::S_BLD_WR;
      end
      rmpss_pkg::S_BLD_WR: begin
        we    = 1'b1;
        waddr = slot(idx_q, lvl_q);
        wdata = merged;
        if (idx_q + WW'(1) + span_b <= WW'(count_q)) begin
          idx_d   = idx_q + WW'(1);
          state_d = rmpss_pkg::S_BLD_LO;
        end else begin
          lvl_d   = lvl_q + LVW'(1);
          state_d = rmpss_pkg::S_BLD_LVL;
        end
      end
      rmpss_pkg::S_Q_WALK: begin
        // Reads for the next level are issued while the previous block is summed in.
        if (span_q <= qlen_q) begin
          raddr   = slot(qleft_q, lvl_q);
          qleft_d = qleft_q + span_q;
          qlen_d  = qlen_q - span_q;
          pend_d  = 1'b1;
        end
        if (lvl_q == '0) begin
          state_d = rmpss_pkg::S_Q_DRAIN;
        end else begin
          lvl_d = lvl_q - LVW'(1);
        end
      end
      rmpss_pkg::S_Q_DRAIN: begin
        done_d  = 1'b1;
        res_d   = pend_q ? acc_next : acc_q;
        state_d = rmpss_pkg::S_IDLE;
      end
      default: begin
        state_d = rmpss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmpss_pkg::S_IDLE;
      count_q     <= '0;
      built_q     <= 1'b0;
      full_pend_q <= 1'b0;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      built_q     <= built_d;
      full_pend_q <= full_pend_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    idx_q   <= idx_d;
    qleft_q <= qleft_d;
    qlen_q  <= qlen_d;
    qsuf_q  <= qsuf_d;
    have_q  <= have_d;
    run_q   <= run_d;
    acc_q   <= acc_d;
    lo_q    <= lo_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
  end

  assign busy_o     = (state_q != rmpss_pkg::S_IDLE);
  assign done_o     = done_q;
  assign best_sum_o = res_q;
  assign status_o   = stat_q;

endmodule

### rtl/rmpss_checker.sv
// ----------------------------------------------------------------------------
// rmpss_checker
// Port-level checks of the range maximum prefix/suffix sum block.
// ----------------------------------------------------------------------------
module rmpss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  command_i,
  input logic        done_o,
  input logic [31:0] best_sum_o,
  input logic [1:0]  status_o
);

  // An error result carries a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != rmpss_pkg::ST_OK)) |-> (best_sum_o == '0))
    else $error("error result with nonzero sum");

  // A good query answer only comes out of the table walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == rmpss_pkg::ST_OK)) |-> $past(busy_o))
    else $error("ok result without a walk");

  // A clear finishes at once and gives no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == rmpss_pkg::CMD_CLEAR)) |=> (!busy_o && !done_o))
    else $error("clear did not complete in one cycle");

  // A query request either answers next cycle or starts the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o &&
     ((command_i == rmpss_pkg::CMD_PREFIX) || (command_i == rmpss_pkg::CMD_SUFFIX)))
    |=> (done_o != busy_o))
    else $error("query neither answered nor walking");

endmodule

bind range_max_prefix_suffix_sum rmpss_checker u_rmpss_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .command_i (command_i),
  .done_o    (done_o),
  .best_sum_o(best_sum_o),
  .status_o  (status_o)
);
